// ===== rtl/vslhd_pkg.sv =====
// Shared constants, register codes and pipeline control type of the velocity slew limiter.
package vslhd_pkg;

    localparam int TIME_BITS  = 48;
    localparam int VEL_W      = 16;
    localparam int ACC_W      = 15;
    localparam int RAD_W      = 16;
    localparam int YAW_W      = 11;
    localparam int PITCH_W    = 12;
    localparam int DB_W       = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int STEP_W     = 16;
    localparam int DT_W       = 32;
    localparam int PROD_W     = ACC_W + DT_W;
    localparam int DEG_W      = 15;
    localparam int HPROD_W    = 31;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_FORWARD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BACKWARD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SIDE_BALL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_YAW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FORWARD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SIDE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_YAW     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_DEADBAND = 3'd7;

    localparam logic [ACC_W-1:0] RST_MAX_FORWARD   = 15'd4096;
    localparam logic [ACC_W-1:0] RST_MAX_BACKWARD  = 15'd614;
    localparam logic [ACC_W-1:0] RST_MAX_SIDE_BALL = 15'd1024;
    localparam logic [ACC_W-1:0] RST_MAX_YAW       = 15'd2458;
    localparam logic [ACC_W-1:0] RST_ACCEL_FORWARD = 15'd4915;
    localparam logic [ACC_W-1:0] RST_ACCEL_SIDE    = 15'd2048;
    localparam logic [ACC_W-1:0] RST_ACCEL_YAW     = 15'd4096;
    localparam logic [DB_W-1:0]  RST_HEAD_DEADBAND = 8'd8;

    localparam logic [DT_W-1:0] FIRST_DT_US = 32'd20000;
    localparam logic [DT_W-1:0] MIN_DT_US   = 32'd1000;

    // accel*dt/1e6 = ((accel*dt) >> 6) / 15625; saturates once the quotient reaches 2^16
    localparam int              Q_SHIFT_W       = PROD_W - 6;
    localparam logic [Q_SHIFT_W-1:0] STEP_SAT_LIMIT = 41'd1024000000;
    localparam logic [30:0]     RECIP_15625     = 31'd1125899907;
    localparam int              RECIP_SHIFT     = 44;
    localparam int              RECIP_PROD_W    = 61;

    localparam logic signed [DEG_W-1:0] DEG_SCALE = 15'sd14668;
    localparam logic signed [DEG_W-1:0] YAW_MIN   = -15'sd800;
    localparam logic signed [DEG_W-1:0] YAW_MAX   = 15'sd800;
    localparam logic signed [DEG_W-1:0] PITCH_MIN = -15'sd320;
    localparam logic signed [DEG_W-1:0] PITCH_MAX = 15'sd1360;

    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
        logic fire2;
        logic fire4;
        logic fire5;
    } pipe_ctrl_t;

endpackage

// ===== rtl/vslhd_timing.sv =====
// Time-delta stage: derives dt from the previous walk timestamp and tracks timing history.
module vslhd_timing (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  vslhd_pkg::pipe_ctrl_t           ctrl,
    input  logic                            walk,
    input  logic [vslhd_pkg::TIME_BITS-1:0] timestamp,
    output logic [vslhd_pkg::DT_W-1:0]      dt,
    output logic                            dt_big
);
    import vslhd_pkg::*;

    logic [TIME_BITS-1:0] prev_time_reg;
    logic                 time_seen_reg;
    logic [TIME_BITS-1:0] diff;
    logic [63:0]          diff_wide;
    logic [DT_W-1:0]      dt_next;
    logic                 big_next;
    logic [DT_W-1:0]      dt_reg;
    logic                 big_reg;

    always_comb begin
        diff      = timestamp - prev_time_reg;
        diff_wide = 64'(diff);
        dt_next   = FIRST_DT_US;
        big_next  = 1'b0;
        priority if (!time_seen_reg) begin
            dt_next = FIRST_DT_US;
        end else if (timestamp < prev_time_reg) begin
            dt_next = MIN_DT_US;
        end else if (|diff_wide[63:DT_W]) begin
            // flag deltas of 2^32 us or more; the step unit saturates them
            dt_next  = '1;
            big_next = 1'b1;
        end else if (diff_wide[DT_W-1:0] < MIN_DT_US) begin
            dt_next = MIN_DT_US;
        end else begin
            dt_next = diff_wide[DT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_time_reg <= '0;
            time_seen_reg <= 1'b0;
        end else if (ctrl.fire2 && walk) begin
            prev_time_reg <= timestamp;
            time_seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld2) begin
            dt_reg  <= dt_next;
            big_reg <= big_next;
        end
    end

    assign dt     = dt_reg;
    assign dt_big = big_reg;

endmodule

// ===== rtl/vslhd_step_unit.sv =====
// Slew step unit: floor(accel * dt / 1e6) saturated to 16 bits, over two pipeline stages.
module vslhd_step_unit (
    input  logic                          aclk,
    input  vslhd_pkg::pipe_ctrl_t         ctrl,
    input  logic [vslhd_pkg::ACC_W-1:0]   accel,
    input  logic [vslhd_pkg::DT_W-1:0]    dt,
    input  logic                          dt_big,
    output logic [vslhd_pkg::STEP_W-1:0]  step
);
    import vslhd_pkg::*;

    logic [PROD_W-1:0]       prod_next;
    logic [PROD_W-1:0]       prod_reg;
    logic                    big_reg;
    logic [Q_SHIFT_W-1:0]    scaled;
    logic                    sat;
    logic [RECIP_PROD_W-1:0] recip_prod;
    logic [STEP_W-1:0]       step_next;
    logic [STEP_W-1:0]       step_reg;

    assign prod_next = PROD_W'(accel) * PROD_W'(dt);

    always_ff @(posedge aclk) begin
        if (ctrl.ld3) begin
            prod_reg <= prod_next;
            big_reg  <= dt_big;
        end
    end

    // divide by 15625 through a reciprocal; exact for the 30-bit range left after saturation
    always_comb begin
        scaled     = prod_reg[PROD_W-1:6];
        sat        = (scaled >= STEP_SAT_LIMIT) || (big_reg && (|prod_reg));
        recip_prod = RECIP_PROD_W'(scaled[29:0]) * RECIP_PROD_W'(RECIP_15625);
        step_next  = sat ? '1 : recip_prod[RECIP_SHIFT+STEP_W-1:RECIP_SHIFT];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld4) begin
            step_reg <= step_next;
        end
    end

    assign step = step_reg;

endmodule

// ===== rtl/vslhd_head.sv =====
// Head path: radians to 1/16 degree, clamp, and deadband check against the last sent angles.
module vslhd_head (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  vslhd_pkg::pipe_ctrl_t               ctrl,
    input  logic signed [vslhd_pkg::RAD_W-1:0]  yaw_rad,
    input  logic signed [vslhd_pkg::RAD_W-1:0]  pitch_rad,
    input  logic [vslhd_pkg::DB_W-1:0]          deadband,
    output logic signed [vslhd_pkg::YAW_W-1:0]  yaw_out,
    output logic signed [vslhd_pkg::PITCH_W-1:0] pitch_out,
    output logic                                send
);
    import vslhd_pkg::*;

    logic signed [HPROD_W-1:0] yaw_prod_next;
    logic signed [HPROD_W-1:0] pitch_prod_next;
    logic signed [HPROD_W-1:0] yaw_prod_reg;
    logic signed [HPROD_W-1:0] pitch_prod_reg;
    logic signed [YAW_W-1:0]   yaw_next;
    logic signed [PITCH_W-1:0] pitch_next;
    logic signed [YAW_W-1:0]   yaw_reg;
    logic signed [PITCH_W-1:0] pitch_reg;
    logic signed [YAW_W-1:0]   sent_yaw_reg;
    logic signed [PITCH_W-1:0] sent_pitch_reg;
    logic signed [12:0]        yaw_diff;
    logic signed [12:0]        pitch_diff;
    logic [12:0]               yaw_abs;
    logic [12:0]               pitch_abs;
    logic                      send_next;
    logic signed [YAW_W-1:0]   yaw_out_reg;
    logic signed [PITCH_W-1:0] pitch_out_reg;
    logic                      send_reg;

    // round to nearest, ties away from zero
    function automatic logic signed [DEG_W-1:0] to_deg16(input logic signed [HPROD_W-1:0] prod);
        logic [HPROD_W-1:0] mag;
        logic [DEG_W-1:0]   q;
        mag = prod[HPROD_W-1] ? HPROD_W'(-prod) : HPROD_W'(prod);
        q   = DEG_W'((mag + HPROD_W'(32768)) >> 16);
        return prod[HPROD_W-1] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [DEG_W-1:0] clamp_deg(input logic signed [DEG_W-1:0] v,
                                                          input logic signed [DEG_W-1:0] lo,
                                                          input logic signed [DEG_W-1:0] hi);
        priority if (v < lo) begin
            return lo;
        end else if (v > hi) begin
            return hi;
        end else begin
            return v;
        end
    endfunction

    assign yaw_prod_next   = HPROD_W'(yaw_rad) * HPROD_W'(DEG_SCALE);
    assign pitch_prod_next = HPROD_W'(pitch_rad) * HPROD_W'(DEG_SCALE);

    always_ff @(posedge aclk) begin
        if (ctrl.ld2) begin
            yaw_prod_reg   <= yaw_prod_next;
            pitch_prod_reg <= pitch_prod_next;
        end
    end

    assign yaw_next   = YAW_W'(clamp_deg(to_deg16(yaw_prod_reg), YAW_MIN, YAW_MAX));
    assign pitch_next = PITCH_W'(clamp_deg(to_deg16(pitch_prod_reg), PITCH_MIN, PITCH_MAX));

    always_ff @(posedge aclk) begin
        if (ctrl.ld3) begin
            yaw_reg   <= yaw_next;
            pitch_reg <= pitch_next;
        end
    end

    always_comb begin
        yaw_diff   = 13'(yaw_reg) - 13'(sent_yaw_reg);
        pitch_diff = 13'(pitch_reg) - 13'(sent_pitch_reg);
        yaw_abs    = 13'(yaw_diff[12] ? -yaw_diff : yaw_diff);
        pitch_abs  = 13'(pitch_diff[12] ? -pitch_diff : pitch_diff);
        send_next  = (yaw_abs >= 13'(deadband)) || (pitch_abs >= 13'(deadband));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sent_yaw_reg   <= '0;
            sent_pitch_reg <= '0;
        end else if (ctrl.fire4 && send_next) begin
            sent_yaw_reg   <= yaw_reg;
            sent_pitch_reg <= pitch_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld4) begin
            yaw_out_reg   <= yaw_reg;
            pitch_out_reg <= pitch_reg;
            send_reg      <= send_next;
        end
    end

    assign yaw_out   = yaw_out_reg;
    assign pitch_out = pitch_out_reg;
    assign send      = send_reg;

endmodule

// ===== rtl/velocity_slew_limiter_with_head_deadband_core.sv =====
// Top level of the velocity clamp-and-slew limiter with head deadband.
//
// Input channel s_*: one transaction per command (walk or stop) with a timestamp, a
// three-axis velocity request and two head angles. Result channel m_*: one transaction
// per input, carrying the limited velocity (zero on stop) and the clamped head angles
// with a send flag. Configuration is a plain write port (cfg_wr_en, cfg_index,
// cfg_wdata); the user must write it only while the block is empty (not enforced).
//
// The datapath is a five-register pipeline: input register, dt and target clamp,
// accel*dt product, reciprocal divide by 1e6 and head deadband, slew and output
// register. An accepted transaction passes through these registers in order to m_*.
// Throughput is one transaction per cycle while m_ready is high; the per-axis
// multipliers set the depth. Each stage advances when empty or when the stage after
// it advances, so bubbles collapse and s_ready stays high while a finished result
// waits on m_ready and an earlier stage is empty. When the receiver stalls, the
// pipeline fills and holds; s_ready falls once full. Reset empties the pipeline,
// restores the register defaults and clears all timing, walk and head history.
module velocity_slew_limiter_with_head_deadband_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [vslhd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vslhd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic [vslhd_pkg::TIME_BITS-1:0]      s_timestamp_us,
    input  logic signed [vslhd_pkg::VEL_W-1:0]   s_walk_dx,
    input  logic signed [vslhd_pkg::VEL_W-1:0]   s_walk_dy,
    input  logic signed [vslhd_pkg::VEL_W-1:0]   s_walk_da,
    input  logic                                 s_ball_focus,
    input  logic signed [vslhd_pkg::RAD_W-1:0]   s_head_yaw_rad,
    input  logic signed [vslhd_pkg::RAD_W-1:0]   s_head_pitch_rad,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_walk_valid,
    output logic signed [vslhd_pkg::VEL_W-1:0]   m_out_dx,
    output logic signed [vslhd_pkg::VEL_W-1:0]   m_out_dy,
    output logic signed [vslhd_pkg::VEL_W-1:0]   m_out_da,
    output logic                                 m_head_send,
    output logic signed [vslhd_pkg::YAW_W-1:0]   m_head_yaw_deg,
    output logic signed [vslhd_pkg::PITCH_W-1:0] m_head_pitch_deg
);
    import vslhd_pkg::*;

    // configuration
    logic [ACC_W-1:0] max_forward_reg;
    logic [ACC_W-1:0] max_backward_reg;
    logic [ACC_W-1:0] max_side_ball_reg;
    logic [ACC_W-1:0] max_yaw_reg;
    logic [ACC_W-1:0] accel_forward_reg;
    logic [ACC_W-1:0] accel_side_reg;
    logic [ACC_W-1:0] accel_yaw_reg;
    logic [DB_W-1:0]  head_deadband_reg;

    // pipeline control
    logic       v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic       ld1, ld2, ld3, ld4, ld5;
    pipe_ctrl_t ctrl;

    // stage 1: input register
    logic                    kind_r1_reg;
    logic [TIME_BITS-1:0]    ts_r1_reg;
    logic signed [VEL_W-1:0] dx_r1_reg, dy_r1_reg, da_r1_reg;
    logic                    focus_r1_reg;
    logic signed [RAD_W-1:0] yaw_rad_r1_reg, pitch_rad_r1_reg;

    // clamped targets travel alongside the step units
    logic signed [VEL_W-1:0] tx_next, ty_next, ta_next;
    logic signed [VEL_W-1:0] tx_r2_reg, ty_r2_reg, ta_r2_reg;
    logic signed [VEL_W-1:0] tx_r3_reg, ty_r3_reg, ta_r3_reg;
    logic signed [VEL_W-1:0] tx_r4_reg, ty_r4_reg, ta_r4_reg;
    logic                    kind_r2_reg, kind_r3_reg, kind_r4_reg;
    logic [VEL_W:0]          side_lim;

    logic [DT_W-1:0]   dt;
    logic              dt_big;
    logic [STEP_W-1:0] step_x, step_y, step_a;

    logic signed [YAW_W-1:0]   head_yaw;
    logic signed [PITCH_W-1:0] head_pitch;
    logic                      head_send;

    // slew state and output register
    logic signed [VEL_W-1:0] prev_dx_reg, prev_dy_reg, prev_da_reg;
    logic signed [VEL_W-1:0] dx_next, dy_next, da_next;
    logic                    walk_valid_reg;
    logic signed [VEL_W-1:0] out_dx_reg, out_dy_reg, out_da_reg;
    logic                    head_send_reg;
    logic signed [YAW_W-1:0]   head_yaw_reg;
    logic signed [PITCH_W-1:0] head_pitch_reg;

    function automatic logic signed [VEL_W-1:0] clamp_vel(input logic signed [VEL_W:0] v,
                                                          input logic signed [VEL_W:0] lo,
                                                          input logic signed [VEL_W:0] hi);
        priority if (v < lo) begin
            return VEL_W'(lo);
        end else if (v > hi) begin
            return VEL_W'(hi);
        end else begin
            return VEL_W'(v);
        end
    endfunction

    function automatic logic signed [VEL_W-1:0] slew(input logic signed [VEL_W-1:0] prev,
                                                     input logic signed [VEL_W-1:0] target,
                                                     input logic [STEP_W-1:0] step);
        logic signed [VEL_W+1:0] d;
        logic signed [VEL_W+1:0] s;
        logic signed [VEL_W+1:0] lim;
        d = (VEL_W+2)'(target) - (VEL_W+2)'(prev);
        s = $signed({2'b00, step});
        priority if (d > s) begin
            lim = s;
        end else if (d < -s) begin
            lim = -s;
        end else begin
            lim = d;
        end
        return VEL_W'((VEL_W+2)'(prev) + lim);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_forward_reg   <= RST_MAX_FORWARD;
            max_backward_reg  <= RST_MAX_BACKWARD;
            max_side_ball_reg <= RST_MAX_SIDE_BALL;
            max_yaw_reg       <= RST_MAX_YAW;
            accel_forward_reg <= RST_ACCEL_FORWARD;
            accel_side_reg    <= RST_ACCEL_SIDE;
            accel_yaw_reg     <= RST_ACCEL_YAW;
            head_deadband_reg <= RST_HEAD_DEADBAND;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MAX_FORWARD:   max_forward_reg   <= cfg_wdata;
                REG_MAX_BACKWARD:  max_backward_reg  <= cfg_wdata;
                REG_MAX_SIDE_BALL: max_side_ball_reg <= cfg_wdata;
                REG_MAX_YAW:       max_yaw_reg       <= cfg_wdata;
                REG_ACCEL_FORWARD: accel_forward_reg <= cfg_wdata;
                REG_ACCEL_SIDE:    accel_side_reg    <= cfg_wdata;
                REG_ACCEL_YAW:     accel_yaw_reg     <= cfg_wdata;
                REG_HEAD_DEADBAND: head_deadband_reg <= cfg_wdata[DB_W-1:0];
            endcase
        end
    end

    // advance a stage when it is empty or the next stage advances
    always_comb begin
        ld5 = !v5_reg || m_ready;
        ld4 = !v4_reg || ld5;
        ld3 = !v3_reg || ld4;
        ld2 = !v2_reg || ld3;
        ld1 = !v1_reg || ld2;
        ctrl.ld2   = ld2;
        ctrl.ld3   = ld3;
        ctrl.ld4   = ld4;
        ctrl.ld5   = ld5;
        ctrl.fire2 = ld2 && v1_reg;
        ctrl.fire4 = ld4 && v3_reg;
        ctrl.fire5 = ld5 && v4_reg;
    end

    assign s_ready = ld1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg <= s_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
            if (ld5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            kind_r1_reg      <= s_kind;
            ts_r1_reg        <= s_timestamp_us;
            dx_r1_reg        <= s_walk_dx;
            dy_r1_reg        <= s_walk_dy;
            da_r1_reg        <= s_walk_da;
            focus_r1_reg     <= s_ball_focus;
            yaw_rad_r1_reg   <= s_head_yaw_rad;
            pitch_rad_r1_reg <= s_head_pitch_rad;
        end
    end

    always_comb begin
        side_lim = focus_r1_reg ? {2'b00, max_side_ball_reg} : '0;
        tx_next  = clamp_vel((VEL_W+1)'(dx_r1_reg), -$signed({2'b00, max_backward_reg}),
                             $signed({2'b00, max_forward_reg}));
        ty_next  = clamp_vel((VEL_W+1)'(dy_r1_reg), -$signed(side_lim), $signed(side_lim));
        ta_next  = clamp_vel((VEL_W+1)'(da_r1_reg), -$signed({2'b00, max_yaw_reg}),
                             $signed({2'b00, max_yaw_reg}));
    end

    always_ff @(posedge aclk) begin
        if (ld2) begin
            kind_r2_reg <= kind_r1_reg;
            tx_r2_reg   <= tx_next;
            ty_r2_reg   <= ty_next;
            ta_r2_reg   <= ta_next;
        end
        if (ld3) begin
            kind_r3_reg <= kind_r2_reg;
            tx_r3_reg   <= tx_r2_reg;
            ty_r3_reg   <= ty_r2_reg;
            ta_r3_reg   <= ta_r2_reg;
        end
        if (ld4) begin
            kind_r4_reg <= kind_r3_reg;
            tx_r4_reg   <= tx_r3_reg;
            ty_r4_reg   <= ty_r3_reg;
            ta_r4_reg   <= ta_r3_reg;
        end
    end

    vslhd_timing u_timing (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .walk      (!kind_r1_reg),
        .timestamp (ts_r1_reg),
        .dt        (dt),
        .dt_big    (dt_big)
    );

    vslhd_step_unit u_step_x (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .accel  (accel_forward_reg),
        .dt     (dt),
        .dt_big (dt_big),
        .step   (step_x)
    );

    vslhd_step_unit u_step_y (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .accel  (accel_side_reg),
        .dt     (dt),
        .dt_big (dt_big),
        .step   (step_y)
    );

    vslhd_step_unit u_step_a (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .accel  (accel_yaw_reg),
        .dt     (dt),
        .dt_big (dt_big),
        .step   (step_a)
    );

    vslhd_head u_head (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .yaw_rad   (yaw_rad_r1_reg),
        .pitch_rad (pitch_rad_r1_reg),
        .deadband  (head_deadband_reg),
        .yaw_out   (head_yaw),
        .pitch_out (head_pitch),
        .send      (head_send)
    );

    // stop drops the walk history and issues zero velocity
    always_comb begin
        dx_next = kind_r4_reg ? '0 : slew(prev_dx_reg, tx_r4_reg, step_x);
        dy_next = kind_r4_reg ? '0 : slew(prev_dy_reg, ty_r4_reg, step_y);
        da_next = kind_r4_reg ? '0 : slew(prev_da_reg, ta_r4_reg, step_a);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_dx_reg <= '0;
            prev_dy_reg <= '0;
            prev_da_reg <= '0;
        end else if (ctrl.fire5) begin
            prev_dx_reg <= dx_next;
            prev_dy_reg <= dy_next;
            prev_da_reg <= da_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld5) begin
            walk_valid_reg <= !kind_r4_reg;
            out_dx_reg     <= dx_next;
            out_dy_reg     <= dy_next;
            out_da_reg     <= da_next;
            head_send_reg  <= head_send;
            head_yaw_reg   <= head_yaw;
            head_pitch_reg <= head_pitch;
        end
    end

    assign m_valid          = v5_reg;
    assign m_walk_valid     = walk_valid_reg;
    assign m_out_dx         = out_dx_reg;
    assign m_out_dy         = out_dy_reg;
    assign m_out_da         = out_da_reg;
    assign m_head_send      = head_send_reg;
    assign m_head_yaw_deg   = head_yaw_reg;
    assign m_head_pitch_deg = head_pitch_reg;

    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_walk_valid |-> m_out_dx == 0 && m_out_dy == 0 && m_out_da == 0)
        else $error("stop transaction carries nonzero velocity");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg |-> s_ready)
        else $error("input register empty but s_ready low");

    a_zero_deadband_sends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && head_deadband_reg == 0 |-> m_head_send)
        else $error("zero deadband did not send head command");

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_head_yaw_deg >= -11'sd800 && m_head_yaw_deg <= 11'sd800 &&
                    m_head_pitch_deg >= -12'sd320 && m_head_pitch_deg <= 12'sd1360)
        else $error("head angle outside clamp range");

endmodule
